/* rtl/echo_pulse_range_framer_macros.svh */
// ----------------------------------------------------------------------------
// Echo pulse range framer assertion macros
// Clocked, reset-qualified assertion wrappers for the framer checker.
// ----------------------------------------------------------------------------
`ifndef ECHO_PULSE_RANGE_FRAMER_MACROS_SVH
`define ECHO_PULSE_RANGE_FRAMER_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define EPR_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define EPR_ASSERT_IMP(label, ante, cons, msg) \
    `EPR_ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define EPR_ASSERT_NXT(label, ante, cons, msg) \
    `EPR_ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

/* rtl/epr_pkg.sv */
// ----------------------------------------------------------------------------
// Echo pulse range framer package
// Shared widths, codes, reset values and types of the framer.
// ----------------------------------------------------------------------------
package epr_pkg;

    localparam int CNT_W       = 16;
    localparam int DIV_W       = 8;
    localparam int CNT_IDX_W   = $clog2(CNT_W);
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
    localparam int RECIP_W     = 17;
    localparam int PROD_W      = CNT_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;
    localparam int CM_W        = PROD_W - RECIP_SHIFT;

    localparam logic [7:0]         SYNC_BYTE     = 8'hFF;
    localparam logic [DIV_W-1:0]   TICKS_RESET   = 8'd12;
    localparam logic [CNT_W-1:0]   TIMEOUT_RESET = 16'd65000;
    // ceil(2^19 / 10): exact quotient by ten for any 16-bit value
    localparam logic [RECIP_W-1:0] RECIP_10      = 17'd52429;

    typedef enum logic [1:0] {
        MODE_RISE = 2'd0,
        MODE_FALL = 2'd1,
        MODE_TICK = 2'd2
    } t_mode;

    typedef enum logic {
        REG_TICKS   = 1'b0,
        REG_TIMEOUT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCALE,
        S_SEND
    } t_back_state;

    typedef struct packed {
        logic [CNT_W-1:0] diff;
    } t_job;

    typedef struct packed {
        logic [DIV_W-1:0] ticks_per_mm;
        logic [CNT_W-1:0] timeout_limit;
    } t_cfg;

endpackage

/* rtl/epr_if.sv */
// ----------------------------------------------------------------------------
// Echo pulse range framer channels
// Valid/ready channels for capture words and frame words.
// ----------------------------------------------------------------------------
interface epr_in_if;
    import epr_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [CNT_W-1:0] capture_time;
    modport source (output valid, output mode, output capture_time, input ready);
    modport sink   (input valid, input mode, input capture_time, output ready);
endinterface

interface epr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

/* rtl/epr_front.sv */
// ----------------------------------------------------------------------------
// Echo pulse range framer front end
// Tracks the edge pairing and queues one pulse width per completed echo.
// ----------------------------------------------------------------------------
module epr_front
    import epr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    epr_in_if.sink      i_in,
    input  t_cfg        i_cfg,
    output logic        o_job_valid,
    input  logic        i_job_ready,
    output t_job        o_job
);

    logic             r_waiting;
    logic             n_waiting;
    logic [CNT_W-1:0] r_start;
    logic [CNT_W-1:0] n_start;
    logic             w_accept;

    assign i_in.ready = i_job_ready;
    assign w_accept   = i_in.valid & i_job_ready;

    always_comb begin
        n_waiting   = r_waiting;
        n_start     = r_start;
        o_job_valid = 1'b0;
        o_job.diff  = '0;
        if (w_accept) begin
            case (i_in.mode)
                MODE_RISE: begin
                    if (!r_waiting) begin
                        n_start   = i_in.capture_time;
                        n_waiting = 1'b1;
                    end
                end
                MODE_FALL: begin
                    if (r_waiting) begin
                        o_job_valid = 1'b1;
                        o_job.diff  = i_in.capture_time - r_start;
                        n_waiting   = 1'b0;
                        n_start     = '0;
                    end
                end
                MODE_TICK: begin
                    // abandon the echo: a zero width yields the zero frame
                    if (r_waiting && (i_in.capture_time > i_cfg.timeout_limit)) begin
                        o_job_valid = 1'b1;
                        n_waiting   = 1'b0;
                        n_start     = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            r_start   <= '0;
        end else begin
            r_waiting <= n_waiting;
            r_start   <= n_start;
        end
    end

endmodule

/* rtl/epr_queue.sv */
// ----------------------------------------------------------------------------
// Echo pulse range framer job queue
// Small FIFO of pulse widths between the front end and the divider.
// ----------------------------------------------------------------------------
module epr_queue
    import epr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_space,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_push;
    logic               w_pop;

    assign o_space = (r_count != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push & o_space;
    assign w_pop   = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/epr_back.sv */
// ----------------------------------------------------------------------------
// Echo pulse range framer back end
// Divides the pulse width, splits cm and mm, and sends the four-word frame.
// ----------------------------------------------------------------------------
module epr_back
    import epr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    output logic        o_job_pop,
    input  t_job        i_job,
    input  t_cfg        i_cfg,
    epr_out_if.source   o_out
);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [CNT_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_div;
    logic [CNT_IDX_W-1:0] r_bit;
    logic [PROD_W-1:0]    r_prod;
    logic [1:0]           r_idx;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic [DIV_W:0]       w_rem_sh;
    logic                 w_ge;
    logic [DIV_W:0]       w_rem_sub;
    logic [CM_W-1:0]      w_cm;
    logic [CNT_W-1:0]     w_cm16;
    logic [CNT_W-1:0]     w_cm10;
    logic [CNT_W-1:0]     w_mm_full;
    logic                 w_load;
    logic [7:0]           w_byte;

    assign w_rem_sh  = {r_rem, r_quo[CNT_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_div});
    assign w_rem_sub = w_rem_sh - {1'b0, r_div};

    assign w_cm      = r_prod[PROD_W-1:RECIP_SHIFT];
    assign w_cm16    = CNT_W'(w_cm);
    assign w_cm10    = (w_cm16 << 3) + (w_cm16 << 1);
    assign w_mm_full = r_quo - w_cm10;

    assign w_load    = (r_state == S_SEND) & (~r_out_valid | o_out.ready);
    assign o_job_pop = (r_state == S_IDLE) & i_job_valid;

    assign o_out.valid      = r_out_valid;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.last_byte  = r_out_last;

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = SYNC_BYTE;
            2'd1:    w_byte = w_cm16[15:8];
            2'd2:    w_byte = w_cm16[7:0];
            default: w_byte = {4'b0, w_mm_full[3:0]};
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_job_valid) n_state = S_DIV;
            S_DIV:   if (r_bit == CNT_IDX_W'(CNT_W - 1)) n_state = S_SCALE;
            S_SCALE: n_state = S_SEND;
            S_SEND:  if (w_load && (r_idx == 2'd3)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath: restoring divide one bit a cycle, then reciprocal scale by ten
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_quo <= i_job.diff;
                r_rem <= '0;
                r_bit <= '0;
                r_idx <= '0;
                r_div <= (i_cfg.ticks_per_mm == '0) ? DIV_W'(1) : i_cfg.ticks_per_mm;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_rem_sub[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
                r_quo <= {r_quo[CNT_W-2:0], w_ge};
                r_bit <= r_bit + 1'b1;
            end
            S_SCALE: begin
                r_prod <= PROD_W'(r_quo) * PROD_W'(RECIP_10);
            end
            S_SEND: begin
                if (w_load) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte <= w_byte;
            r_out_last <= (r_idx == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

/* rtl/echo_pulse_range_framer.sv */
// ----------------------------------------------------------------------------
// Echo pulse range framer
// A falling edge or timeout word passes the two-entry job queue, the 16-step
// bit-serial divider, the scale step and the output register to its first frame
// word. The back end takes one measurement at a time (divide, scale, four output
// words); captures that give no frame are taken every cycle while the queue has room.
// Reset: synchronous, active low; armed for a rising edge, registers at defaults.
// ----------------------------------------------------------------------------
module echo_pulse_range_framer
    import epr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    epr_in_if.sink      i_in,
    epr_out_if.source   o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    t_cfg     r_cfg;
    t_reg_idx w_reg;
    logic     w_wr;
    logic     w_fq_valid;
    logic     w_fq_space;
    t_job     w_fq_job;
    logic     w_qb_valid;
    logic     w_qb_pop;
    t_job     w_qb_job;

    assign o_pready = 1'b1;
    assign w_reg    = t_reg_idx'(i_paddr[2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;

    always_comb begin
        case (w_reg)
            REG_TICKS:   o_prdata = 32'(r_cfg.ticks_per_mm);
            REG_TIMEOUT: o_prdata = 32'(r_cfg.timeout_limit);
            default:     o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_mm  <= TICKS_RESET;
            r_cfg.timeout_limit <= TIMEOUT_RESET;
        end else if (w_wr) begin
            case (w_reg)
                REG_TICKS:   r_cfg.ticks_per_mm  <= i_pwdata[DIV_W-1:0];
                REG_TIMEOUT: r_cfg.timeout_limit <= i_pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    epr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_job_valid (w_fq_valid),
        .i_job_ready (w_fq_space),
        .o_job       (w_fq_job)
    );

    epr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_valid),
        .o_space (w_fq_space),
        .i_job   (w_fq_job),
        .o_valid (w_qb_valid),
        .i_pop   (w_qb_pop),
        .o_job   (w_qb_job)
    );

    epr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qb_valid),
        .o_job_pop   (w_qb_pop),
        .i_job       (w_qb_job),
        .i_cfg       (r_cfg),
        .o_out       (o_out)
    );

endmodule

/* rtl/epr_checker.sv */
// ----------------------------------------------------------------------------
// Echo pulse range framer checker
// Port-level checks on frame order and output word hold.
// ----------------------------------------------------------------------------
`include "echo_pulse_range_framer_macros.svh"

module epr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_frame_byte,
    input logic       i_last_byte
);

    logic [1:0] r_pos;
    logic       w_take;

    assign w_take = i_out_valid & i_out_ready;

    // count words taken within the current frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_take) begin
            r_pos <= r_pos + 1'b1;
        end
    end

    `EPR_ASSERT_NXT(a_valid_hold, i_out_valid && !i_out_ready, i_out_valid, "valid dropped")
    `EPR_ASSERT_IMP(a_sync_first, w_take && (r_pos == 2'd0), i_frame_byte == 8'hFF, "no sync")
    `EPR_ASSERT_IMP(a_last_pos, w_take, i_last_byte == (r_pos == 2'd3), "last misplaced")
    `EPR_ASSERT_IMP(a_mm_digit, w_take && i_last_byte, i_frame_byte <= 8'd9, "mm not a digit")

endmodule

bind echo_pulse_range_framer epr_checker u_epr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_frame_byte (o_out.frame_byte),
    .i_last_byte  (o_out.last_byte)
);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Echo pulse range framer testbench
// Drives capture words and register writes into the framer and predicts every
// range frame word from the echo state and register settings. Checks each
// word in order, with random sender gaps, receiver stalls and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import epr_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         QUIET_LIMIT  = 3000;
    localparam int         SETTLE_TAIL  = 40;

    typedef struct packed {
        logic [1:0]       mode;
        logic [CNT_W-1:0] stamp;
    } t_capture;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       last;
    } t_frame_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_psel;
    logic        i_penable;
    logic        i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    epr_in_if  in_if ();
    epr_out_if out_if ();

    echo_pulse_range_framer uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // stimulus and pacing
    t_capture         captures_todo[$];
    int               n_queued;
    int               n_taken;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               hold_req;
    int               hold_seen;
    int               hold_left;
    logic             in_fire;

    // range predictor state and its copy of the registers
    logic [DIV_W-1:0] cfg_ticks;
    logic [CNT_W-1:0] cfg_timeout;
    logic             echo_waiting;
    logic [CNT_W-1:0] echo_start;
    t_frame_word      frames_due[$];

    int               mismatches;
    int               quiet_cycles;

    always #5 i_clk = ~i_clk;

    function automatic void push_range_frame(input logic [CNT_W-1:0] mm_total);
        logic [31:0] cm;
        cm = mm_total / 10;
        if (cm > 32'hFFFF) begin
            cm = 32'hFFFF;
        end
        frames_due.push_back('{SYNC_BYTE, 1'b0});
        frames_due.push_back('{cm[15:8], 1'b0});
        frames_due.push_back('{cm[7:0], 1'b0});
        frames_due.push_back('{8'(mm_total % 10), 1'b1});
    endfunction

    function automatic void predict_range(input logic [1:0] mode, input logic [CNT_W-1:0] stamp);
        logic [CNT_W-1:0] pulse_ticks;
        logic [DIV_W-1:0] divisor;
        case (mode)
            MODE_RISE: begin
                if (!echo_waiting) begin
                    echo_start   = stamp;
                    echo_waiting = 1'b1;
                end
            end
            MODE_FALL: begin
                if (echo_waiting) begin
                    pulse_ticks  = stamp - echo_start;
                    divisor      = (cfg_ticks == '0) ? DIV_W'(1) : cfg_ticks;
                    echo_waiting = 1'b0;
                    echo_start   = '0;
                    push_range_frame(pulse_ticks / divisor);
                end
            end
            MODE_TICK: begin
                if (echo_waiting && stamp > cfg_timeout) begin
                    echo_waiting = 1'b0;
                    echo_start   = '0;
                    push_range_frame('0);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void queue_capture(input logic [1:0] mode, input logic [CNT_W-1:0] stamp);
        captures_todo.push_back('{mode, stamp});
        n_queued++;
    endfunction

    // mostly rise/fall pairs with stray ticks, the rest pure noise
    task automatic queue_random(input int count);
        int               made;
        logic [CNT_W-1:0] t0;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 99) < 75) begin
                t0 = CNT_W'($urandom);
                queue_capture(MODE_RISE, t0);
                made++;
                repeat ($urandom_range(0, 2)) begin
                    if ($urandom_range(0, 1)) begin
                        queue_capture(MODE_TICK, cfg_timeout + CNT_W'($urandom_range(0, 1)));
                    end else begin
                        queue_capture(MODE_TICK, CNT_W'($urandom));
                    end
                    made++;
                end
                if ($urandom_range(0, 1)) begin
                    queue_capture(MODE_FALL, t0 + CNT_W'($urandom_range(0, 3000)));
                end else begin
                    queue_capture(MODE_FALL, CNT_W'($urandom));
                end
                made++;
            end else begin
                queue_capture(2'($urandom_range(0, 3)), CNT_W'($urandom));
                made++;
            end
        end
    endtask

    task automatic set_pace(input int send_pct, input int recv_pct);
        @(posedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // wait until every word is taken and every frame has come back
    task automatic settle();
        do @(negedge i_clk); while (n_taken != n_queued || frames_due.size() != 0);
        repeat (SETTLE_TAIL) @(negedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= value;
        @(negedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        case (idx)
            REG_TICKS:   cfg_ticks   = value[DIV_W-1:0];
            REG_TIMEOUT: cfg_timeout = value[CNT_W-1:0];
            default: begin
            end
        endcase
    endtask

    // capture driver
    always @(negedge i_clk) begin
        t_capture nxt;
        if (!i_rst_n) begin
            in_if.valid        <= 1'b0;
            in_if.mode         <= '0;
            in_if.capture_time <= '0;
        end else if (!in_if.valid || in_fire) begin
            if (captures_todo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = captures_todo.pop_front();
                in_if.valid        <= 1'b1;
                in_if.mode         <= nxt.mode;
                in_if.capture_time <= nxt.stamp;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // frame receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_seen    <= 0;
        end else if (hold_left != 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            out_if.ready <= 1'b0;
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_frame_word want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready) begin
                predict_range(in_if.mode, in_if.capture_time);
                n_taken++;
            end
            if (out_if.valid && out_if.ready) begin
                if (frames_due.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected frame word %h last %b",
                                 out_if.frame_byte, out_if.last_byte);
                    end
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    if (out_if.frame_byte !== want.fbyte || out_if.last_byte !== want.last) begin
                        if (mismatches < 10) begin
                            $display("frame word mismatch: expected %h last %b, got %h last %b",
                                     want.fbyte, want.last, out_if.frame_byte, out_if.last_byte);
                        end
                        mismatches++;
                    end
                end
            end
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || (i_psel && i_penable && i_pwrite && o_pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_psel             = 1'b0;
        i_penable          = 1'b0;
        i_pwrite           = 1'b0;
        i_paddr            = '0;
        i_pwdata           = '0;
        in_if.valid        = 1'b0;
        in_if.mode         = '0;
        in_if.capture_time = '0;
        out_if.ready       = 1'b0;
        in_fire            = 1'b0;
        n_queued           = 0;
        n_taken            = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_req           = 0;
        hold_seen          = 0;
        hold_left          = 0;
        mismatches         = 0;
        quiet_cycles       = 0;
        cfg_ticks          = TICKS_RESET;
        cfg_timeout        = TIMEOUT_RESET;
        echo_waiting       = 1'b0;
        echo_start         = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words at the reset register values
        set_pace(0, 0);
        queue_capture(MODE_FALL, 16'h1234);     // falling edge while armed: drop
        queue_capture(MODE_TICK, 16'hFFFF);     // tick while armed: drop
        queue_capture(MODE_UNUSED, 16'hFFFF);
        queue_capture(MODE_RISE, 16'h0000);
        queue_capture(MODE_RISE, 16'hAAAA);     // second rise while waiting: drop
        queue_capture(MODE_TICK, 16'd65000);    // equal to limit: keep waiting
        queue_capture(MODE_FALL, 16'hFFFF);     // widest pulse
        queue_capture(MODE_RISE, 16'hFFF0);
        queue_capture(MODE_FALL, 16'h0010);     // counter wraps
        queue_capture(MODE_RISE, 16'h5555);
        queue_capture(MODE_TICK, 16'd65001);    // just past limit: zero frame
        queue_capture(MODE_FALL, 16'h6000);
        queue_capture(MODE_RISE, 16'h8000);
        queue_capture(MODE_FALL, 16'h8000);     // zero width
        queue_capture(MODE_RISE, 16'h0000);
        queue_capture(MODE_UNUSED, 16'h0000);
        queue_capture(MODE_TICK, 16'hFFFF);
        queue_capture(MODE_RISE, 16'h1234);
        queue_capture(MODE_FALL, 16'h1233);     // full wrap minus one
        settle();

        reg_write(REG_TICKS, 32'd1);
        reg_write(REG_TIMEOUT, 32'd0);
        set_pace(56, 0);
        queue_random(20);
        settle();

        reg_write(REG_TICKS, 32'd255);
        reg_write(REG_TIMEOUT, 32'd65535);
        set_pace(0, 56);
        queue_random(20);
        settle();

        // a divisor of zero acts as one
        reg_write(REG_TICKS, 32'd0);
        reg_write(REG_TIMEOUT, 32'($urandom_range(20000, 60000)));
        set_pace(16, 16);
        queue_random(20);
        settle();

        reg_write(REG_TICKS, 32'($urandom_range(2, 254)));
        reg_write(REG_TIMEOUT, 32'($urandom_range(0, 65535)));
        set_pace(0, 0);
        hold_req = hold_req + 1;
        queue_random(20);
        settle();

        if (mismatches == 0 && frames_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/epr_pkg.sv
rtl/epr_if.sv
rtl/epr_front.sv
rtl/epr_queue.sv
rtl/epr_back.sv
rtl/echo_pulse_range_framer.sv
rtl/epr_checker.sv
verif/tb.sv
